FILE: hdl/saamc_pkg.sv
`timescale 1ns / 1ps

package saamc_pkg;

  localparam int HALF_W = 64;
  localparam int TIME_W = 16;
  localparam int FOLD_W = 16;
  localparam logic [TIME_W-1:0] TTL_RESET = 16'd1024;

  typedef enum logic [1:0] {
    OP_LOOKUP = 2'd0,
    OP_UPDATE = 2'd1,
    OP_REMOVE = 2'd2,
    OP_AGE    = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH,
    S_EXEC
  } state_t;

  typedef struct packed {
    op_t               op;
    logic [HALF_W-1:0] key_lo;
    logic [HALF_W-1:0] key_hi;
    logic [HALF_W-1:0] new_lo;
    logic [HALF_W-1:0] new_hi;
    logic              touch;
    logic              insert_on_miss;
    logic [7:0]        set_index;
    logic [TIME_W-1:0] now;
  } item_t;

  typedef struct packed {
    logic [HALF_W-1:0] val_hi;
    logic [HALF_W-1:0] val_lo;
    logic [HALF_W-1:0] tag_hi;
    logic [HALF_W-1:0] tag_lo;
  } line_t;

  typedef struct packed {
    logic              hit;
    logic [HALF_W-1:0] found_lo;
    logic [HALF_W-1:0] found_hi;
    logic [1:0]        way;
    logic [3:0]        cleared_ways;
  } result_t;

  function automatic logic [FOLD_W-1:0] fold16(input logic [HALF_W-1:0] x);
    return x[15:0] ^ x[31:16] ^ x[47:32] ^ x[63:48];
  endfunction

endpackage

FILE: hdl/saamc_ram.sv
`timescale 1ns / 1ps

module saamc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hdl/saamc_setmod.sv
`timescale 1ns / 1ps

module saamc_setmod import saamc_pkg::*; #(
  parameter int SETS = 256
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic [FOLD_W-1:0]       x,
  output logic                    done,
  output logic [$clog2(SETS)-1:0] rem
);

  localparam int SET_W = $clog2(SETS);

  generate
    if ((SETS & (SETS - 1)) == 0) begin : g_mask
      assign done = start;
      assign rem  = x[SET_W-1:0];
    end else begin : g_recip
      // The quotient estimate from the reciprocal is at most one below the true quotient,
      // so a single compare and subtract finishes the remainder.
      localparam logic [31:0] RECIP   = 32'(64'h1_0000_0000 / 64'(SETS));
      localparam logic [16:0] SETS_17 = 17'(SETS);

      logic [47:0]       prod;
      logic [31:0]       back;
      logic [FOLD_W-1:0] xq;
      logic [FOLD_W-1:0] quo;
      logic [16:0]       diff;
      logic              s1;
      logic              s2;

      assign prod = 48'(x) * 48'(RECIP);
      assign back = 32'(quo) * 32'(SETS);

      always_ff @(posedge clk) begin
        if (rst) begin
          s1 <= 1'b0;
          s2 <= 1'b0;
        end else begin
          s1 <= start;
          s2 <= s1;
        end
      end

      always_ff @(posedge clk) begin
        if (start) begin
          xq  <= x;
          quo <= prod[47:32];
        end
        if (s1) begin
          diff <= 17'(32'(xq) - back);
        end
      end

      assign done = s2;
      assign rem  = (diff >= SETS_17) ? SET_W'(diff - SETS_17) : diff[SET_W-1:0];
    end
  endgenerate

endmodule

FILE: hdl/saamc_exec.sv
`timescale 1ns / 1ps

module saamc_exec import saamc_pkg::*; #(
  parameter int WAYS = 4
) (
  input  item_t                         item,
  input  logic [TIME_W-1:0]             ttl,
  input  logic [WAYS-1:0]               valid_rd,
  input  logic [WAYS-1:0][TIME_W-1:0]   time_rd,
  input  line_t [WAYS-1:0]              line_rd,
  output logic [WAYS-1:0]               valid_wr,
  output logic [WAYS-1:0][TIME_W-1:0]   time_wr,
  output line_t [WAYS-1:0]              line_wr,
  output result_t                       res
);

  localparam int WAY_W = $clog2(WAYS);

  logic [WAYS-1:0]   match;
  logic [WAY_W-1:0]  low_idx;
  logic [WAY_W-1:0]  inv_idx;
  logic [WAY_W-1:0]  lru_idx;
  logic [WAY_W-1:0]  tgt;
  logic              any_hit;
  logic              any_inv;
  logic [TIME_W-1:0] best;
  logic [TIME_W-1:0] age;
  logic [WAYS-1:0]   cleared;
  logic [WAYS+3:0]   cleared_pad;

  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      match[w] = valid_rd[w] && line_rd[w].tag_lo == item.key_lo
                 && line_rd[w].tag_hi == item.key_hi;
    end
    any_hit = |match;
    any_inv = ~&valid_rd;

    low_idx = '0;
    inv_idx = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (match[w]) begin
        low_idx = WAY_W'(w);
      end
      if (!valid_rd[w]) begin
        inv_idx = WAY_W'(w);
      end
    end

    lru_idx = '0;
    best    = time_rd[0];
    for (int w = 1; w < WAYS; w++) begin
      if (time_rd[w] < best) begin
        best    = time_rd[w];
        lru_idx = WAY_W'(w);
      end
    end

    valid_wr = valid_rd;
    time_wr  = time_rd;
    line_wr  = line_rd;
    res      = '0;
    cleared  = '0;
    age      = '0;
    tgt      = any_hit ? low_idx : (any_inv ? inv_idx : lru_idx);

    case (item.op)
      OP_LOOKUP: begin
        res.hit = any_hit;
        if (any_hit) begin
          res.way      = 2'(low_idx);
          res.found_lo = line_rd[low_idx].val_lo;
          res.found_hi = line_rd[low_idx].val_hi;
          if (item.touch) begin
            time_wr[low_idx] = item.now;
          end
        end
      end
      OP_UPDATE: begin
        res.hit = any_hit;
        if (any_hit || item.insert_on_miss) begin
          res.way       = 2'(tgt);
          valid_wr[tgt] = 1'b1;
          time_wr[tgt]  = item.now;
          line_wr[tgt]  = '{val_hi: item.new_hi, val_lo: item.new_lo,
                            tag_hi: item.key_hi, tag_lo: item.key_lo};
        end
      end
      OP_REMOVE: begin
        res.hit  = any_hit;
        res.way  = 2'(low_idx);
        valid_wr = valid_rd & ~match;
        cleared  = match;
      end
      OP_AGE: begin
        for (int w = 0; w < WAYS; w++) begin
          age = item.now - time_rd[w];
          if (age > ttl) begin
            valid_wr[w] = 1'b0;
            cleared[w]  = valid_rd[w];
          end
        end
      end
      default: begin
        res = '0;
      end
    endcase

    cleared_pad      = {4'b0000, cleared};
    res.cleared_ways = cleared_pad[3:0];
  end

endmodule

FILE: hdl/set_assoc_address_map_cache_top.sv
`timescale 1ns / 1ps

// Channel | Handshake                | Payload
// in      | in_valid / in_stall      | op, key_lo, key_hi, new_lo, new_hi, touch,
//         |                          | insert_on_miss, set_index, now
// out     | out_valid / out_stall    | hit, found_lo, found_hi, way, cleared_ways
// cfg     | cfg_valid / cfg_ready    | cfg_ttl
//
// When SETS is a power of two, the set row is first read from the tag and metadata
// memories, then the chosen way is written back and the result registered. Otherwise
// the set index first passes through the registered set remainder unit.
// After reset a clearing pass writes SETS metadata rows, one a cycle, before items
// are accepted. A stalled output holds the next item in the write-back cycle.
module set_assoc_address_map_cache_top import saamc_pkg::*; #(
  parameter int SETS = 256,
  parameter int WAYS = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        op,
  input  logic [63:0]       key_lo,
  input  logic [63:0]       key_hi,
  input  logic [63:0]       new_lo,
  input  logic [63:0]       new_hi,
  input  logic              touch,
  input  logic              insert_on_miss,
  input  logic [7:0]        set_index,
  input  logic [15:0]       now,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              hit,
  output logic [63:0]       found_lo,
  output logic [63:0]       found_hi,
  output logic [1:0]        way,
  output logic [3:0]        cleared_ways,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [15:0]       cfg_ttl
);

  localparam int SET_W   = $clog2(SETS);
  localparam bit IS_POW2 = (SETS & (SETS - 1)) == 0;
  localparam int META_W  = WAYS * (1 + TIME_W);
  localparam int DATA_W  = WAYS * $bits(line_t);
  localparam logic [SET_W-1:0] LAST_SET = SET_W'(SETS - 1);

  state_t                      state;
  state_t                      state_next;
  item_t                       item_q;
  logic [SET_W-1:0]            set_q;
  logic [SET_W-1:0]            clr_idx;
  logic [TIME_W-1:0]           ttl;
  logic                        accept;
  logic                        exec_fire;
  logic                        set_load;
  logic [FOLD_W-1:0]           mod_x;
  logic                        mod_done;
  logic [SET_W-1:0]            mod_rem;
  logic [SET_W-1:0]            rd_addr;
  logic [SET_W-1:0]            wr_addr;
  logic                        meta_we;
  logic [META_W-1:0]           meta_wdata;
  logic [META_W-1:0]           meta_rdata;
  logic [DATA_W-1:0]           data_rdata;
  logic [WAYS-1:0]             valid_rd;
  logic [WAYS-1:0][TIME_W-1:0] time_rd;
  line_t [WAYS-1:0]            line_rd;
  logic [WAYS-1:0]             valid_wr;
  logic [WAYS-1:0][TIME_W-1:0] time_wr;
  line_t [WAYS-1:0]            line_wr;
  result_t                     res;

  assign in_stall  = state != S_IDLE;
  assign accept    = in_valid && !in_stall;
  assign exec_fire = state == S_EXEC && (!out_valid || !out_stall);
  assign cfg_ready = 1'b1;

  assign mod_x = (op_t'(op) == OP_AGE) ? {8'h00, set_index}
                                       : (fold16(key_lo) ^ fold16(key_hi));

  saamc_setmod #(.SETS(SETS)) u_setmod (
    .clk   (clk),
    .rst   (rst),
    .start (accept),
    .x     (mod_x),
    .done  (mod_done),
    .rem   (mod_rem)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      clr_idx <= '0;
      ttl     <= TTL_RESET;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) begin
        clr_idx <= clr_idx + 1'b1;
      end
      if (cfg_valid && cfg_ready) begin
        ttl <= cfg_ttl;
      end
    end
  end

  always_comb begin
    state_next = state;
    set_load   = 1'b0;
    case (state)
      S_CLEAR: begin
        if (clr_idx == LAST_SET) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          if (IS_POW2) begin
            set_load   = 1'b1;
            state_next = S_EXEC;
          end else begin
            state_next = S_HASH;
          end
        end
      end
      S_HASH: begin
        if (mod_done) begin
          set_load   = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (exec_fire) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_q <= '{op: op_t'(op), key_lo: key_lo, key_hi: key_hi, new_lo: new_lo,
                  new_hi: new_hi, touch: touch, insert_on_miss: insert_on_miss,
                  set_index: set_index, now: now};
    end
    if (set_load) begin
      set_q <= mod_rem;
    end
  end

  assign rd_addr    = (state == S_EXEC) ? set_q : mod_rem;
  assign wr_addr    = (state == S_CLEAR) ? clr_idx : set_q;
  assign meta_we    = state == S_CLEAR || exec_fire;
  assign meta_wdata = (state == S_CLEAR) ? '0 : {valid_wr, time_wr};

  saamc_ram #(.WIDTH(META_W), .DEPTH(SETS)) u_meta_ram (
    .clk   (clk),
    .we    (meta_we),
    .waddr (wr_addr),
    .wdata (meta_wdata),
    .raddr (rd_addr),
    .rdata (meta_rdata)
  );

  saamc_ram #(.WIDTH(DATA_W), .DEPTH(SETS)) u_data_ram (
    .clk   (clk),
    .we    (exec_fire),
    .waddr (set_q),
    .wdata (line_wr),
    .raddr (rd_addr),
    .rdata (data_rdata)
  );

  assign valid_rd = meta_rdata[META_W-1 -: WAYS];
  assign time_rd  = meta_rdata[WAYS*TIME_W-1:0];
  assign line_rd  = data_rdata;

  saamc_exec #(.WAYS(WAYS)) u_exec (
    .item     (item_q),
    .ttl      (ttl),
    .valid_rd (valid_rd),
    .time_rd  (time_rd),
    .line_rd  (line_rd),
    .valid_wr (valid_wr),
    .time_wr  (time_wr),
    .line_wr  (line_wr),
    .res      (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (exec_fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_fire) begin
      hit          <= res.hit;
      found_lo     <= res.found_lo;
      found_hi     <= res.found_hi;
      way          <= res.way;
      cleared_ways <= res.cleared_ways;
    end
  end

  a_out_from_exec: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_EXEC))
    else $error("Result presented without a write-back cycle.");

  a_accept_moves_on: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == S_EXEC || state == S_HASH))
    else $error("Accepted item did not start its set access.");

  a_exec_holds: assert property (@(posedge clk) disable iff (rst)
    (state == S_EXEC && !exec_fire) |=> (state == S_EXEC && out_valid))
    else $error("Write-back left while the output register was stalled.");

endmodule

FILE: test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import saamc_pkg::*;

  localparam int NUM_SETS   = 256;
  localparam int NUM_WAYS   = 4;
  localparam int ENTRIES    = NUM_SETS * NUM_WAYS;
  localparam int IDLE_LIMIT = 2000;

  logic clk = 1'b0;
  logic rst;
  logic in_valid;
  logic in_stall;
  item_t drive_item;
  logic out_valid;
  logic out_stall;
  logic hit;
  logic [63:0] found_lo;
  logic [63:0] found_hi;
  logic [1:0] way;
  logic [3:0] cleared_ways;
  logic cfg_valid;
  logic cfg_ready;
  logic [15:0] cfg_ttl;

  logic way_valid [ENTRIES];
  logic [15:0] way_time [ENTRIES];
  logic [127:0] tag_mem [ENTRIES];
  logic [127:0] val_mem [ENTRIES];
  logic [15:0] ttl_q;

  result_t pending_results[$];
  logic [127:0] key_pool [32];
  logic [7:0] hot_sets [4];
  logic [127:0] dkey [10];
  logic [15:0] now_units;
  bit quiet;
  int stall_left;
  int errors;
  int idle_cycles;

  set_assoc_address_map_cache_top #(
    .SETS(NUM_SETS),
    .WAYS(NUM_WAYS)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .op(drive_item.op),
    .key_lo(drive_item.key_lo),
    .key_hi(drive_item.key_hi),
    .new_lo(drive_item.new_lo),
    .new_hi(drive_item.new_hi),
    .touch(drive_item.touch),
    .insert_on_miss(drive_item.insert_on_miss),
    .set_index(drive_item.set_index),
    .now(drive_item.now),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .hit(hit),
    .found_lo(found_lo),
    .found_hi(found_hi),
    .way(way),
    .cleared_ways(cleared_ways),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_ttl(cfg_ttl)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic logic [15:0] xor_fold(input logic [63:0] x);
    logic [15:0] acc;
    acc = '0;
    for (int i = 0; i < 4; i++) acc ^= x[i*16 +: 16];
    return acc;
  endfunction

  function automatic logic [7:0] key_set(input logic [63:0] lo, input logic [63:0] hi);
    logic [15:0] f;
    f = xor_fold(lo) ^ xor_fold(hi);
    return f[7:0];
  endfunction

  function automatic logic [1:0] lowest_way(input logic [3:0] m);
    logic [1:0] l;
    l = '0;
    for (int w = NUM_WAYS - 1; w >= 0; w--) if (m[w]) l = 2'(w);
    return l;
  endfunction

  function automatic result_t apply_to_map(input item_t it);
    result_t r;
    int base;
    int e;
    int victim;
    logic [3:0] hits;
    logic [15:0] age;
    logic [15:0] oldest;
    r = '0;
    hits = '0;
    if (it.op == OP_AGE) begin
      base = int'(it.set_index) * NUM_WAYS;
      for (int w = 0; w < NUM_WAYS; w++) begin
        age = it.now - way_time[base + w];
        if (age > ttl_q) begin
          if (way_valid[base + w]) r.cleared_ways[w] = 1'b1;
          way_valid[base + w] = 1'b0;
        end
      end
    end else begin
      base = int'(key_set(it.key_lo, it.key_hi)) * NUM_WAYS;
      for (int w = 0; w < NUM_WAYS; w++) begin
        if (way_valid[base + w] && tag_mem[base + w] == {it.key_hi, it.key_lo}) hits[w] = 1'b1;
      end
      r.hit = |hits;
      case (it.op)
        OP_LOOKUP: begin
          if (r.hit) begin
            r.way = lowest_way(hits);
            e = base + int'(r.way);
            r.found_lo = val_mem[e][63:0];
            r.found_hi = val_mem[e][127:64];
            if (it.touch) way_time[e] = it.now;
          end
        end
        OP_UPDATE: begin
          if (r.hit || it.insert_on_miss) begin
            if (r.hit) begin
              victim = int'(lowest_way(hits));
            end else begin
              victim = -1;
              for (int w = NUM_WAYS - 1; w >= 0; w--) if (!way_valid[base + w]) victim = w;
              if (victim < 0) begin
                victim = 0;
                oldest = way_time[base];
                for (int w = 1; w < NUM_WAYS; w++) begin
                  if (way_time[base + w] < oldest) begin
                    oldest = way_time[base + w];
                    victim = w;
                  end
                end
              end
            end
            e = base + victim;
            way_valid[e] = 1'b1;
            tag_mem[e] = {it.key_hi, it.key_lo};
            val_mem[e] = {it.new_hi, it.new_lo};
            way_time[e] = it.now;
            r.way = 2'(victim);
          end
        end
        OP_REMOVE: begin
          if (r.hit) begin
            r.way = lowest_way(hits);
            for (int w = 0; w < NUM_WAYS; w++) if (hits[w]) way_valid[base + w] = 1'b0;
            r.cleared_ways = hits;
          end
        end
        default: ;
      endcase
    end
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  function automatic logic [127:0] key_in_set(input logic [7:0] s);
    logic [63:0] lo;
    logic [63:0] hi;
    logic [15:0] f;
    lo = {$urandom, $urandom};
    hi = {$urandom, $urandom};
    f = xor_fold(lo) ^ xor_fold(hi);
    lo[15:0] = lo[15:0] ^ f ^ {f[15:8], s};
    return {hi, lo};
  endfunction

  function automatic item_t cmd(input op_t o, input logic [127:0] key, input logic [127:0] val,
                                input bit tch, input bit ins, input logic [7:0] si,
                                input logic [15:0] t);
    item_t it;
    it.op = o;
    {it.key_hi, it.key_lo} = key;
    {it.new_hi, it.new_lo} = val;
    it.touch = tch;
    it.insert_on_miss = ins;
    it.set_index = si;
    it.now = t;
    return it;
  endfunction

  function automatic item_t random_item();
    item_t it;
    int r;
    r = $urandom_range(0, 99);
    if (r < 35) it.op = OP_LOOKUP;
    else if (r < 70) it.op = OP_UPDATE;
    else if (r < 82) it.op = OP_REMOVE;
    else it.op = OP_AGE;
    if ($urandom_range(0, 99) < 85) begin
      {it.key_hi, it.key_lo} = key_pool[$urandom_range(0, 31)];
    end else begin
      it.key_lo = {$urandom, $urandom};
      it.key_hi = {$urandom, $urandom};
    end
    it.new_lo = {$urandom, $urandom};
    it.new_hi = {$urandom, $urandom};
    it.touch = 1'($urandom_range(0, 1));
    it.insert_on_miss = ($urandom_range(0, 4) != 0);
    if ($urandom_range(0, 3) != 0) it.set_index = hot_sets[$urandom_range(0, 3)];
    else it.set_index = 8'($urandom_range(0, 255));
    if ($urandom_range(0, 49) == 0) now_units = 16'($urandom_range(0, 65535));
    else now_units = now_units + 16'($urandom_range(0, 40));
    it.now = now_units;
    return it;
  endfunction

  task automatic send_item(input item_t it);
    int gap;
    gap = quiet ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    drive_item <= it;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    pending_results.push_back(apply_to_map(it));
    @(negedge clk);
  endtask

  task automatic write_ttl(input logic [15:0] value);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_ttl <= value;
    do @(posedge clk); while (!cfg_ready);
    ttl_q = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0h, got %0h", name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("result arrived with nothing outstanding");
        errors++;
      end else begin
        want = pending_results.pop_front();
        check_field("hit", 64'(want.hit), 64'(hit));
        check_field("found_lo", want.found_lo, found_lo);
        check_field("found_hi", want.found_hi, found_hi);
        check_field("way", 64'(want.way), 64'(way));
        check_field("cleared_ways", 64'(want.cleared_ways), 64'(cleared_ways));
      end
    end
  end

  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left = stall_left - 1;
    end else begin
      out_stall <= 1'b0;
      if (!quiet && $urandom_range(0, 2) == 0) stall_left = pick_gap();
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("tb_top: done, errors");
        $finish;
      end
    end
  end

  task automatic test_basic_ops();
    for (int i = 0; i < 5; i++) dkey[i] = key_in_set(8'h5a);
    for (int i = 5; i < 10; i++) dkey[i] = key_in_set(8'hc3);
    send_item(cmd(OP_LOOKUP, dkey[0], '0, 1'b1, 1'b1, 8'd0, 16'd0));
    send_item(cmd(OP_UPDATE, dkey[0], '1, 1'b0, 1'b0, 8'd0, 16'd0));
    send_item(cmd(OP_UPDATE, dkey[0], '1, 1'b0, 1'b1, 8'd0, 16'd10));
    send_item(cmd(OP_UPDATE, dkey[1], '0, 1'b0, 1'b1, 8'd0, 16'd20));
    send_item(cmd(OP_UPDATE, dkey[2], {4{$urandom}}, 1'b0, 1'b1, 8'd0, 16'd30));
    send_item(cmd(OP_UPDATE, dkey[3], {4{$urandom}}, 1'b0, 1'b1, 8'd0, 16'd5));
    send_item(cmd(OP_LOOKUP, dkey[0], '0, 1'b1, 1'b0, 8'd0, 16'd40));
    // The set is full, so the least recently used way gives way.
    send_item(cmd(OP_UPDATE, dkey[4], {4{$urandom}}, 1'b0, 1'b1, 8'd0, 16'd50));
    send_item(cmd(OP_UPDATE, dkey[1], {4{$urandom}}, 1'b0, 1'b0, 8'd0, 16'd50));
    send_item(cmd(OP_LOOKUP, dkey[3], '0, 1'b0, 1'b0, 8'd0, 16'd50));
    send_item(cmd(OP_REMOVE, dkey[1], '0, 1'b0, 1'b0, 8'd0, 16'd50));
    send_item(cmd(OP_REMOVE, dkey[1], '0, 1'b0, 1'b0, 8'd0, 16'd50));
    // Equal access times everywhere: the lowest way is replaced.
    for (int i = 5; i < 10; i++) begin
      send_item(cmd(OP_UPDATE, dkey[i], {4{$urandom}}, 1'b0, 1'b1, 8'd0, 16'd7));
    end
    send_item(cmd(OP_UPDATE, '0, '1, 1'b1, 1'b1, 8'hff, 16'hffff));
    send_item(cmd(OP_LOOKUP, '0, '0, 1'b1, 1'b0, 8'hff, 16'hffff));
    send_item(cmd(OP_UPDATE, '1, '0, 1'b0, 1'b1, 8'h00, 16'h0000));
    send_item(cmd(OP_LOOKUP, '1, '1, 1'b0, 1'b0, 8'h00, 16'h0000));
  endtask

  task automatic test_ageing();
    write_ttl(16'd100);
    send_item(cmd(OP_AGE, '0, '0, 1'b0, 1'b0, 8'h5a, 16'd150));
    send_item(cmd(OP_AGE, '0, '0, 1'b0, 1'b0, 8'h5a, 16'd151));
    // The time has wrapped below the stored times, so every way looks old.
    send_item(cmd(OP_AGE, '0, '0, 1'b0, 1'b0, 8'hc3, 16'd5));
    write_ttl(16'd0);
    send_item(cmd(OP_UPDATE, dkey[0], '1, 1'b0, 1'b1, 8'd0, 16'd200));
    send_item(cmd(OP_AGE, '0, '0, 1'b0, 1'b0, 8'h5a, 16'd200));
    send_item(cmd(OP_AGE, '0, '0, 1'b0, 1'b0, 8'h5a, 16'd201));
    write_ttl(16'hffff);
    send_item(cmd(OP_UPDATE, dkey[0], '1, 1'b0, 1'b1, 8'd0, 16'd0));
    send_item(cmd(OP_AGE, '0, '0, 1'b0, 1'b0, 8'h5a, 16'hffff));
  endtask

  task automatic test_random_traffic(input logic [15:0] ttl_value, input int count,
                                     input bit no_idle);
    write_ttl(ttl_value);
    quiet = no_idle;
    for (int i = 0; i < 4; i++) hot_sets[i] = 8'($urandom_range(0, 255));
    for (int i = 0; i < 32; i++) key_pool[i] = key_in_set(hot_sets[i % 4]);
    repeat (count) send_item(random_item());
  endtask

  task automatic finish_run();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (errors == 0) $display("tb_top: done, clean");
    else $display("tb_top: done, errors");
    $finish;
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    drive_item = '0;
    out_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_ttl = '0;
    quiet = 1'b0;
    stall_left = 0;
    errors = 0;
    idle_cycles = 0;
    now_units = '0;
    ttl_q = TTL_RESET;
    for (int e = 0; e < ENTRIES; e++) begin
      way_valid[e] = 1'b0;
      way_time[e] = '0;
      tag_mem[e] = '0;
      val_mem[e] = '0;
    end
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_basic_ops();
    test_ageing();
    test_random_traffic(TTL_RESET, 300, 1'b0);
    test_random_traffic(16'd0, 250, 1'b0);
    test_random_traffic(16'hffff, 250, 1'b0);
    test_random_traffic(16'($urandom_range(20, 200)), 300, 1'b0);
    test_random_traffic(16'($urandom_range(0, 65535)), 220, 1'b0);
    test_random_traffic(16'($urandom_range(20, 200)), 300, 1'b1);
    finish_run();
  end

endmodule
